// ===== sv/psc_pkg.sv =====
// shared types and constants for the point set collision check
// depends on nothing; imported by every module of the block except psc_ram

package psc_pkg;

   // coordinate widths: stored offsets and exact global sums
   localparam int COORD_W = 12;
   localparam int SUM_W   = COORD_W + 1;
   localparam int PT_W    = 2 * COORD_W;

   // request action codes
   localparam logic [1:0] ACT_LOAD_ONE = 2'd0;
   localparam logic [1:0] ACT_LOAD_TWO = 2'd1;
   localparam logic [1:0] ACT_POINT    = 2'd2;
   localparam logic [1:0] ACT_OVERLAP  = 2'd3;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_ADD,
      ST_SCAN,
      ST_DRAIN,
      ST_RESP
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic take_target;
      logic scan;
      logic next_outer;
      logic resp_load;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic empty;
      logic inner_last;
      logic outer_last;
      logic hit_now;
      logic rsp_free;
   } sts_type;

endpackage

// ===== sv/psc_ram.sv =====
// generic single write port, single read port memory with registered read
// no dependencies

module psc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/psc_ctrl.sv =====
// controller state machine: sequences loads, the nested compare scan and the response
// depends on psc_pkg

module psc_ctrl
   import psc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_action,
   output logic       req_ready,
   input  sts_type    sts,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      req_ready       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (req_action)
                  ACT_LOAD_ONE, ACT_LOAD_TWO: state_in = ST_IDLE;
                  ACT_POINT:   state_in = sts.empty ? ST_RESP : ST_SCAN;
                  ACT_OVERLAP: state_in = sts.empty ? ST_RESP : ST_FETCH;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         // outer point read is in flight
         ST_FETCH: state_in = ST_ADD;
         ST_ADD: begin
            cmd.take_target = 1'b1;
            state_in        = ST_SCAN;
         end
         // one shape two point read per cycle
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.inner_last) begin
               state_in = ST_DRAIN;
            end
         end
         // last compare of the inner pass lands here
         ST_DRAIN: begin
            if (sts.hit_now || sts.outer_last) begin
               state_in = ST_RESP;
            end else begin
               cmd.next_outer = 1'b1;
               state_in       = ST_FETCH;
            end
         end
         ST_RESP: begin
            if (sts.rsp_free) begin
               cmd.resp_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== sv/psc_datapath.sv =====
// datapath: shape memories, counts, scan indexes, target and compare, output register
// depends on psc_pkg and psc_ram

module psc_datapath
   import psc_pkg::*;
#(
   parameter int MAX_POINTS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [1:0]                req_action,
   input  logic                      req_restart,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic signed [COORD_W-1:0] req_pos_one_x,
   input  logic signed [COORD_W-1:0] req_pos_one_y,
   input  logic signed [COORD_W-1:0] req_pos_two_x,
   input  logic signed [COORD_W-1:0] req_pos_two_y,
   input  cmd_type                   cmd,
   output sts_type                   sts,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_hit
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   logic [CNT_W-1:0] cnt1_ff, cnt1_in, cnt2_ff, cnt2_in;
   logic [CNT_W-1:0] cnt1_m1, cnt2_m1;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in;
   logic             wr1_en, wr2_en;
   logic [IDX_W-1:0] wr1_addr, wr2_addr;
   logic [PT_W-1:0]  wr_data, rd1_data, rd2_data;

   logic signed [COORD_W-1:0] p1x_ff, p1y_ff, p2x_ff, p2y_ff;
   logic signed [SUM_W-1:0]   tx_ff, tx_in, ty_ff, ty_in;
   logic signed [SUM_W-1:0]   gx2, gy2;
   logic                      is_point_ff, is_point_in;
   logic                      cmp_vld_ff, hit_ff, hit_in, match;
   logic                      rsp_valid_ff, rsp_valid_in, rsp_hit_ff;

   // load decode: restart goes to entry zero, a full list drops the point
   always_comb begin
      wr1_en   = cmd.accept && (req_action == ACT_LOAD_ONE) &&
                 (req_restart || (cnt1_ff != CNT_W'(MAX_POINTS)));
      wr2_en   = cmd.accept && (req_action == ACT_LOAD_TWO) &&
                 (req_restart || (cnt2_ff != CNT_W'(MAX_POINTS)));
      wr1_addr = req_restart ? '0 : cnt1_ff[IDX_W-1:0];
      wr2_addr = req_restart ? '0 : cnt2_ff[IDX_W-1:0];
      wr_data  = {req_point_x, req_point_y};
      cnt1_in  = cnt1_ff;
      cnt2_in  = cnt2_ff;
      if (wr1_en) begin
         cnt1_in = req_restart ? CNT_W'(1) : cnt1_ff + CNT_W'(1);
      end
      if (wr2_en) begin
         cnt2_in = req_restart ? CNT_W'(1) : cnt2_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt1_ff <= '0;
         cnt2_ff <= '0;
      end else begin
         cnt1_ff <= cnt1_in;
         cnt2_ff <= cnt2_in;
      end
   end

   psc_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_ram_one (
      .clock   (clock),
      .wr_en   (wr1_en),
      .wr_addr (wr1_addr),
      .wr_data (wr_data),
      .rd_addr (i_ff),
      .rd_data (rd1_data)
   );

   psc_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_ram_two (
      .clock   (clock),
      .wr_en   (wr2_en),
      .wr_addr (wr2_addr),
      .wr_data (wr_data),
      .rd_addr (j_ff),
      .rd_data (rd2_data)
   );

   // scan indexes and target point
   always_comb begin
      i_in        = i_ff;
      j_in        = j_ff;
      tx_in       = tx_ff;
      ty_in       = ty_ff;
      is_point_in = is_point_ff;
      if (cmd.accept) begin
         i_in        = '0;
         j_in        = '0;
         is_point_in = (req_action == ACT_POINT);
         tx_in       = SUM_W'(req_point_x);
         ty_in       = SUM_W'(req_point_y);
      end else if (cmd.next_outer) begin
         i_in = IDX_W'(i_ff + 1'b1);
         j_in = '0;
      end else if (cmd.scan) begin
         j_in = IDX_W'(j_ff + 1'b1);
      end
      if (cmd.take_target) begin
         tx_in = SUM_W'($signed(rd1_data[PT_W-1:COORD_W])) + SUM_W'(p1x_ff);
         ty_in = SUM_W'($signed(rd1_data[COORD_W-1:0])) + SUM_W'(p1y_ff);
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      is_point_ff <= is_point_in;
      if (cmd.accept) begin
         p1x_ff <= req_pos_one_x;
         p1y_ff <= req_pos_one_y;
         p2x_ff <= req_pos_two_x;
         p2y_ff <= req_pos_two_y;
      end
   end

   // shape two point placed at its position against the target
   always_comb begin
      gx2    = SUM_W'($signed(rd2_data[PT_W-1:COORD_W])) + SUM_W'(p2x_ff);
      gy2    = SUM_W'($signed(rd2_data[COORD_W-1:0])) + SUM_W'(p2y_ff);
      match  = (gx2 == tx_ff) && (gy2 == ty_ff);
      hit_in = hit_ff;
      if (cmd.accept) begin
         hit_in = 1'b0;
      end else if (cmp_vld_ff && match) begin
         hit_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan;
         hit_ff     <= hit_in;
      end
   end

   // output register, freed when the response is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.resp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.resp_load) begin
         rsp_hit_ff <= hit_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   // status
   always_comb begin
      cnt1_m1        = cnt1_ff - CNT_W'(1);
      cnt2_m1        = cnt2_ff - CNT_W'(1);
      sts.empty      = (cnt2_ff == '0) ||
                       ((req_action == ACT_OVERLAP) && (cnt1_ff == '0));
      sts.inner_last = (j_ff == cnt2_m1[IDX_W-1:0]);
      sts.outer_last = is_point_ff || (i_ff == cnt1_m1[IDX_W-1:0]);
      sts.hit_now    = hit_ff || (cmp_vld_ff && match);
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

// ===== sv/point_set_collision_check.sv =====
// Point set collision check. Loads give no response; the block is ready again in the next
// cycle. A point query scans shape two once, one stored point a cycle, then answers. An
// overlap query reads one shape one point, then scans shape two against it, for each shape
// one point in turn, and stops after the first point pass that finds a hit. Each shape
// memory has a single read port. A query on an empty shape answers no hit without a scan.
// Depends on psc_pkg, psc_ctrl, psc_datapath and psc_ram.

module point_set_collision_check
   import psc_pkg::*;
#(
   parameter int MAX_POINTS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_action,
   input  logic                      req_restart,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic signed [COORD_W-1:0] req_pos_one_x,
   input  logic signed [COORD_W-1:0] req_pos_one_y,
   input  logic signed [COORD_W-1:0] req_pos_two_x,
   input  logic signed [COORD_W-1:0] req_pos_two_y,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_hit
);

   cmd_type cmd;
   sts_type sts;

   psc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   psc_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_action    (req_action),
      .req_restart   (req_restart),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_pos_one_x (req_pos_one_x),
      .req_pos_one_y (req_pos_one_y),
      .req_pos_two_x (req_pos_two_x),
      .req_pos_two_y (req_pos_two_y),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hit       (rsp_hit)
   );

`ifndef SYNTH
   // a load request never makes the block busy
   a_load_keeps_ready: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready &&
       (req_action == ACT_LOAD_ONE || req_action == ACT_LOAD_TWO)) |=> req_ready)
      else $error("load request left the block busy");

   // a query request always makes the block busy in the cycle after its acceptance
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready &&
       (req_action == ACT_POINT || req_action == ACT_OVERLAP)) |=> !req_ready)
      else $error("query request did not occupy the block");

   // a response appears only out of query work
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without a query in progress");
`endif

endmodule

// ===== test/tb_point_set_collision_check.sv =====
// self-checking testbench for point_set_collision_check: directed table, then random shapes
// depends on psc_pkg and the point_set_collision_check rtl; needs nothing else
`timescale 1ns / 1ps

module tb_point_set_collision_check
   import psc_pkg::*;
();

   localparam int MAX_PTS     = 64;
   localparam int ITEM_TARGET = 1250;
   // longest quiet stretch: full-by-full overlap scan plus both idle draws
   localparam int STALL_LIMIT = 4 * (MAX_PTS * (MAX_PTS + 3) + 2 * 13 + 8);
   localparam int TAIL_CYCLES = 2 * MAX_PTS;
   localparam int CMIN        = -(1 << (COORD_W - 1));
   localparam int CMAX        = (1 << (COORD_W - 1)) - 1;

   typedef logic signed [COORD_W-1:0] coord_type;

   // where the expected answer of a request comes from
   typedef enum logic [1:0] {
      BY_MODEL,
      KNOWN_MISS,
      KNOWN_HIT
   } answer_src_type;

   typedef struct {
      logic [1:0]     action;
      logic           restart;
      coord_type      point_x;
      coord_type      point_y;
      coord_type      pos_one_x;
      coord_type      pos_one_y;
      coord_type      pos_two_x;
      coord_type      pos_two_y;
      answer_src_type answer;
   } shape_req_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic          rsp_valid;
   logic          rsp_ready;
   logic          rsp_hit;
   shape_req_type cur_req;

   // shadow copy of both shapes
   coord_type shape_x [2][MAX_PTS];
   coord_type shape_y [2][MAX_PTS];
   int        shape_n [2];

   bit            open_hits [$];
   shape_req_type directed_plan [$];
   bit            model_answers;
   bit            model_hit;
   bit            want_hit;
   int            req_calm;
   int            rsp_calm;
   int            idle_cycles;
   int            error_count;
   int            sent_count;
   int            loads_taken;
   int            loads_dropped;
   int            point_queries;
   int            overlap_queries;
   int            checked_count;
   int            hits_seen;

   point_set_collision_check #(
      .MAX_POINTS(MAX_PTS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (cur_req.action),
      .req_restart   (cur_req.restart),
      .req_point_x   (cur_req.point_x),
      .req_point_y   (cur_req.point_y),
      .req_pos_one_x (cur_req.pos_one_x),
      .req_pos_one_y (cur_req.pos_one_y),
      .req_pos_two_x (cur_req.pos_two_x),
      .req_pos_two_y (cur_req.pos_two_y),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hit       (rsp_hit)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // known values on every input from time zero
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      rsp_ready = 1'b0;
      cur_req   = '{2'b00, 1'b0, '0, '0, '0, '0, '0, '0, BY_MODEL};
      shape_n   = '{0, 0};
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // does a global point lie on shape two placed at (bx, by)
   function automatic bit covered_by_two(input int gx, input int gy, input int bx, input int by);
      for (int i = 0; i < shape_n[1]; i++) begin
         if (int'(shape_x[1][i]) + bx == gx && int'(shape_y[1][i]) + by == gy)
            return 1'b1;
      end
      return 1'b0;
   endfunction

   // update the shadow shapes and work out the answer of one request
   function automatic void apply_request(input shape_req_type r, output bit answers,
                                         output bit hit);
      int s;
      answers = 1'b0;
      hit     = 1'b0;
      case (r.action)
         ACT_LOAD_ONE, ACT_LOAD_TWO: begin
            s = (r.action == ACT_LOAD_TWO) ? 1 : 0;
            loads_taken++;
            if (r.restart)
               shape_n[s] = 0;
            if (shape_n[s] < MAX_PTS) begin
               shape_x[s][shape_n[s]] = r.point_x;
               shape_y[s][shape_n[s]] = r.point_y;
               shape_n[s]++;
            end else begin
               loads_dropped++;
            end
         end
         ACT_POINT: begin
            answers = 1'b1;
            point_queries++;
            hit = covered_by_two(int'(r.point_x), int'(r.point_y),
                                 int'(r.pos_two_x), int'(r.pos_two_y));
         end
         default: begin
            answers = 1'b1;
            overlap_queries++;
            for (int i = 0; i < shape_n[0] && !hit; i++)
               hit = covered_by_two(int'(shape_x[0][i]) + int'(r.pos_one_x),
                                    int'(shape_y[0][i]) + int'(r.pos_one_y),
                                    int'(r.pos_two_x), int'(r.pos_two_y));
         end
      endcase
   endfunction

   // request and response monitor, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            apply_request(cur_req, model_answers, model_hit);
            if (model_answers) begin
               case (cur_req.answer)
                  KNOWN_HIT:  open_hits.push_back(1'b1);
                  KNOWN_MISS: open_hits.push_back(1'b0);
                  default:    open_hits.push_back(model_hit);
               endcase
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (open_hits.size() == 0) begin
               report_mismatch($sformatf("response hit=%0b with no open query", rsp_hit));
            end else begin
               want_hit = open_hits.pop_front();
               checked_count++;
               if (rsp_hit === 1'b1)
                  hits_seen++;
               if (rsp_hit !== want_hit)
                  report_mismatch($sformatf("response %0d hit=%0b, expected %0b",
                                            checked_count, rsp_hit, want_hit));
            end
         end
      end
   end

   // watchdog on cycles in which nothing moves
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: nothing accepted for %0d cycles", idle_cycles);
         $display("tb_point_set_collision_check failed");
         $finish;
      end
   end

   // idle draw with occasional stretches of back-to-back traffic
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0)
         calm = $urandom_range(8, 40);
      return $urandom_range(0, 12);
   endfunction

   function automatic int pick_in(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic coord_type fit(input int v);
      return coord_type'((v < CMIN) ? CMIN : ((v > CMAX) ? CMAX : v));
   endfunction

   function automatic coord_type near(input int base, input int span);
      return fit(base + pick_in(-span, span));
   endfunction

   // positions so that a_off + pa == b_off + pb, both in range
   function automatic void aim(input int a_off, input int b_off, output coord_type pa,
                               output coord_type pb);
      int d;
      int pick;
      d    = b_off - a_off;
      pick = pick_in((d > 0) ? CMIN : CMIN - d, (d > 0) ? CMAX - d : CMAX);
      pb   = coord_type'(pick);
      pa   = coord_type'(pick + d);
   endfunction

   function automatic shape_req_type any_request();
      shape_req_type r;
      r.action    = 2'($urandom_range(0, 3));
      r.restart   = 1'($urandom_range(0, 1));
      r.point_x   = coord_type'($urandom_range(0, 4095));
      r.point_y   = coord_type'($urandom_range(0, 4095));
      r.pos_one_x = coord_type'($urandom_range(0, 4095));
      r.pos_one_y = coord_type'($urandom_range(0, 4095));
      r.pos_two_x = coord_type'($urandom_range(0, 4095));
      r.pos_two_y = coord_type'($urandom_range(0, 4095));
      r.answer    = BY_MODEL;
      return r;
   endfunction

   function automatic shape_req_type req_row(input logic [1:0] action, input logic restart,
                                             input int px, input int py, input int ax,
                                             input int ay, input int bx, input int by,
                                             input answer_src_type answer);
      shape_req_type r;
      r = '{action, restart, coord_type'(px), coord_type'(py), coord_type'(ax),
            coord_type'(ay), coord_type'(bx), coord_type'(by), answer};
      return r;
   endfunction

   // shape length: mostly short, sometimes past the limit
   function automatic int pick_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8)
         return 0;
      if (roll < 75)
         return $urandom_range(1, 6);
      if (roll < 93)
         return $urandom_range(7, 20);
      return $urandom_range(MAX_PTS - 2, MAX_PTS + 6);
   endfunction

   // one request; entered and left at a falling edge
   task automatic send_request(input shape_req_type r);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      cur_req   <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   // reload both shapes, then a burst of queries aimed at hits about half the time
   task automatic run_episode();
      int            span;
      int            n;
      int            q_total;
      int            i;
      int            j;
      shape_req_type r;
      span = ($urandom_range(0, 4) == 0) ? CMAX : $urandom_range(1, 4);
      for (int s = 0; s < 2; s++) begin
         n = pick_length();
         for (int k = 0; k < n; k++) begin
            r         = any_request();
            r.action  = (s == 0) ? ACT_LOAD_ONE : ACT_LOAD_TWO;
            r.restart = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 49) == 0);
            r.point_x = near(0, span);
            r.point_y = near(0, span);
            send_request(r);
         end
      end
      q_total = $urandom_range(2, 8);
      for (int q = 0; q < q_total; q++) begin
         r = any_request();
         // one query in ten is left as raw noise
         if ($urandom_range(0, 9) != 0) begin
            r.action = $urandom_range(0, 1) ? ACT_POINT : ACT_OVERLAP;
            if (span < CMAX) begin
               r.pos_two_x = near(0, CMAX - 7);
               r.pos_two_y = near(0, CMAX - 7);
               r.pos_one_x = near(int'(r.pos_two_x), 6);
               r.pos_one_y = near(int'(r.pos_two_y), 6);
               r.point_x   = near(int'(r.pos_two_x), span + 2);
               r.point_y   = near(int'(r.pos_two_y), span + 2);
            end
            if ($urandom_range(0, 1) == 1 && shape_n[1] > 0) begin
               j = $urandom_range(0, shape_n[1] - 1);
               if (r.action == ACT_POINT) begin
                  aim(0, int'(shape_x[1][j]), r.point_x, r.pos_two_x);
                  aim(0, int'(shape_y[1][j]), r.point_y, r.pos_two_y);
               end else if (shape_n[0] > 0) begin
                  i = $urandom_range(0, shape_n[0] - 1);
                  aim(int'(shape_x[0][i]), int'(shape_x[1][j]), r.pos_one_x, r.pos_two_x);
                  aim(int'(shape_y[0][i]), int'(shape_y[1][j]), r.pos_one_y, r.pos_two_y);
               end
            end
         end
         send_request(r);
      end
   endtask

   // response side: per response, an optional hold-off once it shows up
   initial begin : rsp_side
      int gap;
      wait (!reset);
      forever begin
         gap = draw_gap(rsp_calm);
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
            while (!rsp_valid) @(posedge clock);
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // main sequence
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table: empty shapes, extremes, exact sums, append, restart
      directed_plan = '{
         req_row(ACT_POINT,    1'b1,     0,     0,     5,     5,     0,     0, KNOWN_MISS),
         req_row(ACT_OVERLAP,  1'b0,     0,     0,     0,     0,     0,     0, KNOWN_MISS),
         req_row(ACT_LOAD_ONE, 1'b1,     0,     0,  2047, -2048,  2047, -2048, BY_MODEL),
         req_row(ACT_OVERLAP,  1'b1, -2048,  2047,     0,     0,     0,     0, KNOWN_MISS),
         req_row(ACT_LOAD_TWO, 1'b1,     0,     0,    -1,    -1,    -1,    -1, BY_MODEL),
         req_row(ACT_POINT,    1'b0,  2047,  2047,     0,     0,  2047,  2047, KNOWN_HIT),
         req_row(ACT_POINT,    1'b0,  2047,  2046,     0,     0,  2047,  2047, KNOWN_MISS),
         req_row(ACT_OVERLAP,  1'b0,     0,     0, -2048, -2048, -2048, -2048, KNOWN_HIT),
         req_row(ACT_OVERLAP,  1'b0,     0,     0, -2048, -2048,  2047,  2047, KNOWN_MISS),
         req_row(ACT_LOAD_ONE, 1'b1,  2047,  2047, -1234,   777,    -1,     0, BY_MODEL),
         req_row(ACT_LOAD_TWO, 1'b1, -2048, -2048,  1365, -1366,  2047, -2048, BY_MODEL),
         req_row(ACT_OVERLAP,  1'b0,     0,     0, -2048, -2048,  2047,  2047, KNOWN_HIT),
         req_row(ACT_POINT,    1'b0,     0,     0,     0,     0, -2048, -2048, KNOWN_MISS),
         req_row(ACT_POINT,    1'b0,    -1,    -1,     0,     0,  2047,  2047, KNOWN_HIT),
         req_row(ACT_OVERLAP,  1'b0,     0,     0,  2047,  2047,  2046,  2046, KNOWN_MISS),
         req_row(ACT_LOAD_TWO, 1'b0,     5,    -3,   -77,    12,   300,  -300, BY_MODEL),
         req_row(ACT_LOAD_ONE, 1'b0,    -7,     9,  1000,  -999,     3,     3, BY_MODEL),
         req_row(ACT_OVERLAP,  1'b0,     0,     0,    22,    -2,    10,    10, BY_MODEL),
         req_row(ACT_POINT,    1'b1,    15,     7,    -5,    -5,    10,    10, BY_MODEL),
         req_row(ACT_LOAD_ONE, 1'b1,     0,     0,    44,    55,    66,    77, BY_MODEL),
         req_row(ACT_OVERLAP,  1'b0,     0,     0,    15,     7,    10,    10, BY_MODEL),
         req_row(ACT_LOAD_TWO, 1'b1,   100,  -100,     0,     0,     0,     0, BY_MODEL),
         req_row(ACT_POINT,    1'b0,    15,     7,     0,     0,    10,    10, BY_MODEL),
         req_row(ACT_OVERLAP,  1'b0,     0,     0,   110,   -90,    10,    10, BY_MODEL)
      };
      foreach (directed_plan[k])
         send_request(directed_plan[k]);

      // random shapes and queries
      while (sent_count < ITEM_TARGET)
         run_episode();
      req_valid <= 1'b0;

      // drain open queries, then watch for stray responses
      while (open_hits.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("%0d requests: %0d loads (%0d dropped on a full shape), %0d point, %0d overlap",
               sent_count, loads_taken, loads_dropped, point_queries, overlap_queries);
      $display("%0d responses checked, %0d hits, %0d mismatches",
               checked_count, hits_seen, error_count);
      if (error_count == 0)
         $display("tb_point_set_collision_check passed");
      else
         $display("tb_point_set_collision_check failed");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/psc_pkg.sv
sv/psc_ram.sv
sv/psc_ctrl.sv
sv/psc_datapath.sv
sv/point_set_collision_check.sv
test/tb_point_set_collision_check.sv
